// ----- sv/emas_pkg.sv -----
// Package for the SMA-seeded exponential moving average block.
// Field widths, fixed-point constants, register indexes and sequencer codes.
// No dependencies.
package emas_pkg;

  localparam int PRICE_W    = 40;
  localparam int TIME_W     = 40;
  localparam int SUM_W      = 52;
  localparam int CNT_W      = 13;
  localparam int ALPHA_W    = 17;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_WINDOW = 4096;
  localparam int ALU_W      = 60;
  localparam int REM_W      = 13;
  localparam int STEP_W     = 6;
  localparam int DIV_STEPS  = SUM_W;
  localparam int MUL_STEPS  = ALPHA_W;
  localparam int CFG_W      = 17;
  localparam int IN_W       = PRICE_W + TIME_W;
  localparam int OUT_W      = PRICE_W + TIME_W;

  localparam logic [CNT_W-1:0]     WIN_RESET   = CNT_W'(10);
  localparam logic [ALPHA_W-1:0]   ALPHA_RESET = ALPHA_W'(11915);
  localparam logic [ALPHA_W-1:0]   ALPHA_ONE   = ALPHA_W'(1 << FRAC_BITS);
  localparam logic [FRAC_BITS-1:0] HALF_LSB    = FRAC_BITS'(1 << (FRAC_BITS - 1));
  localparam logic [CNT_W-1:0]     WIN_MAX     = CNT_W'(MAX_WINDOW);

  localparam logic CFG_WINDOW = 1'b0;
  localparam logic CFG_ALPHA  = 1'b1;

  typedef logic [2:0] state_t;
  localparam state_t ST_IDLE = 3'd0;
  localparam state_t ST_SUM  = 3'd1;
  localparam state_t ST_DIV  = 3'd2;
  localparam state_t ST_MUL  = 3'd3;
  localparam state_t ST_EMIT = 3'd4;

endpackage

// ----- sv/emas_alu.sv -----
// Shared add/subtract unit for the moving average sequencer.
// Serves the seed sum, the restoring divide and the shift-add multiply; uses emas_pkg.
module emas_alu import emas_pkg::*; (
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  input  logic             sub,
  output logic [ALU_W-1:0] y
);

  assign y = sub ? (a - b) : (a + b);

endmodule

// ----- sv/ema_with_sma_seed.sv -----
// SMA-seeded exponential moving average, one shared adder under a sequencer.
// A seeding sample with no result is only added to the sum; the seed is formed by a
// 52-step restoring divide and an EMA update by a 17-step shift-add multiply.
// One sample at a time; in_tready is low from transfer until the sample is summed or its result is queued.
// Synchronous active-low reset: window 10, alpha 11915, sum/count/average zero.
module ema_with_sma_seed import emas_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [IN_W-1:0]    in_tdata,   // close_price[39:0], timestamp[79:40]
  input  logic               in_tuser,   // series_start
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata,  // average_value[39:0], result_time[79:40]
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     win_r;
  logic [ALPHA_W-1:0]   alpha_r;
  logic [CNT_W-1:0]     samples_r, samples_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [PRICE_W-1:0]   avg_r, avg_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r, out_data_nxt;

  logic [PRICE_W-1:0]   x_r;
  logic [TIME_W-1:0]    ts_r;
  logic                 start_r;
  logic [REM_W-1:0]     rem_r, rem_nxt;
  logic [SUM_W-1:0]     quo_r, quo_nxt;
  logic [ALU_W-1:0]     acc_r, acc_nxt;
  logic [ALU_W-1:0]     dsh_r, dsh_nxt;
  logic [ALPHA_W-1:0]   alp_r, alp_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;

  logic [ALU_W-1:0]     alu_a, alu_b, alu_y;
  logic                 alu_sub;
  logic [CNT_W-1:0]     win_eff;
  logic [ALPHA_W-1:0]   alpha_eff;
  logic [CNT_W-1:0]     cnt_base;
  logic [SUM_W-1:0]     sum_base;
  logic [SUM_W-1:0]     sum_new;
  logic [REM_W-1:0]     div_t;
  logic                 q_bit;

  emas_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign win_eff   = (win_r == '0) ? CNT_W'(1) : ((win_r > WIN_MAX) ? WIN_MAX : win_r);
  assign alpha_eff = (alpha_r > ALPHA_ONE) ? ALPHA_ONE : alpha_r;
  assign cnt_base  = start_r ? '0 : samples_r;
  assign sum_base  = start_r ? '0 : sum_r;
  assign div_t     = {rem_r[REM_W-2:0], quo_r[SUM_W-1]};

  always_comb begin
    state_nxt     = state_r;
    samples_nxt   = samples_r;
    sum_nxt       = sum_r;
    avg_nxt       = avg_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    acc_nxt       = acc_r;
    dsh_nxt       = dsh_r;
    alp_nxt       = alp_r;
    step_nxt      = step_r;
    alu_a         = '0;
    alu_b         = '0;
    alu_sub       = 1'b0;
    sum_new       = '0;
    q_bit         = 1'b0;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        if (cnt_base < win_eff) begin
          alu_a       = ALU_W'(sum_base);
          alu_b       = ALU_W'(x_r);
          sum_new     = alu_y[SUM_W] ? '1 : alu_y[SUM_W-1:0];
          sum_nxt     = sum_new;
          samples_nxt = cnt_base + CNT_W'(1);
          if (samples_nxt == win_eff) begin
            rem_nxt   = '0;
            quo_nxt   = sum_new;
            step_nxt  = STEP_W'(DIV_STEPS - 1);
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          samples_nxt = cnt_base;
          sum_nxt     = sum_base;
          alu_a       = ALU_W'(x_r);
          alu_b       = ALU_W'(avg_r);
          alu_sub     = 1'b1;
          dsh_nxt     = alu_y;
          acc_nxt     = ALU_W'({avg_r, HALF_LSB});
          alp_nxt     = alpha_eff;
          step_nxt    = STEP_W'(MUL_STEPS - 1);
          state_nxt   = ST_MUL;
        end
      end
      ST_DIV: begin
        alu_a   = ALU_W'(div_t);
        alu_b   = ALU_W'(win_eff);
        alu_sub = 1'b1;
        if (!alu_y[ALU_W-1]) begin
          rem_nxt = alu_y[REM_W-1:0];
          q_bit   = 1'b1;
        end else begin
          rem_nxt = div_t;
        end
        quo_nxt = {quo_r[SUM_W-2:0], q_bit};
        if (step_r == '0) begin
          avg_nxt   = (|quo_nxt[SUM_W-1:PRICE_W]) ? '1 : quo_nxt[PRICE_W-1:0];
          state_nxt = ST_EMIT;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      ST_MUL: begin
        alu_a   = acc_r;
        alu_b   = alp_r[0] ? dsh_r : '0;
        acc_nxt = alu_y;
        dsh_nxt = {dsh_r[ALU_W-2:0], 1'b0};
        alp_nxt = {1'b0, alp_r[ALPHA_W-1:1]};
        if (step_r == '0) begin
          avg_nxt   = (|alu_y[ALU_W-1:FRAC_BITS+PRICE_W]) ? '1
                      : alu_y[FRAC_BITS+PRICE_W-1:FRAC_BITS];
          state_nxt = ST_EMIT;
        end else begin
          step_nxt = step_r - STEP_W'(1);
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {ts_r, avg_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_r       <= WIN_RESET;
      alpha_r     <= ALPHA_RESET;
      samples_r   <= '0;
      sum_r       <= '0;
      avg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      samples_r   <= samples_nxt;
      sum_r       <= sum_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW: win_r   <= cfg_data[CNT_W-1:0];
          CFG_ALPHA:  alpha_r <= cfg_data[ALPHA_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      x_r     <= in_tdata[PRICE_W-1:0];
      ts_r    <= in_tdata[IN_W-1:PRICE_W];
      start_r <= in_tuser;
    end
    out_data_r <= out_data_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    acc_r      <= acc_nxt;
    dsh_r      <= dsh_nxt;
    alp_r      <= alp_nxt;
    step_r     <= step_nxt;
  end

endmodule

// ----- sv/emas_chk.sv -----
// Port-level checker for ema_with_sma_seed, attached by bind.
// Watches the stream handshakes only; uses emas_pkg.
module emas_chk import emas_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after input transfer");

  a_no_instant_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared one cycle after input transfer");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset left block busy or valid");

endmodule

bind ema_with_sma_seed emas_chk u_emas_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- test/ema_with_sma_seed_checker.sv -----
// Checker for the SMA-seeded EMA block: tracks register writes and input
// transfers, predicts each average and compares it with the result transfers.
// Depends on emas_pkg.
`timescale 1ns / 1ps
module ema_with_sma_seed_checker import emas_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             in_tuser,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [TIME_W-1:0]  result_time;
    logic [PRICE_W-1:0] average_value;
  } avg_result_t;

  logic [CNT_W-1:0]   window_reg;
  logic [ALPHA_W-1:0] alpha_reg;
  logic [CNT_W-1:0]   samples_seen;
  logic [SUM_W-1:0]   seed_sum;
  logic [PRICE_W-1:0] average_reg;
  avg_result_t        expected_avgs[$];
  int                 errors;

  initial begin
    errors = 0;
  end

  task automatic update_average(input logic [PRICE_W-1:0] price,
                                input logic [TIME_W-1:0] stamp, input logic start);
    logic [CNT_W-1:0]   win;
    logic [ALPHA_W-1:0] weight;
    logic [SUM_W:0]     wide_sum;
    logic [63:0]        quot;
    logic [63:0]        blend;
    avg_result_t        next_avg;
    win = (window_reg == '0) ? CNT_W'(1) : ((window_reg > WIN_MAX) ? WIN_MAX : window_reg);
    weight = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    if (start) begin
      samples_seen = '0;
      seed_sum = '0;
    end
    if (samples_seen < win) begin
      wide_sum = {1'b0, seed_sum} + (SUM_W+1)'(price);
      seed_sum = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
      samples_seen = samples_seen + 1'b1;
      if (samples_seen != win) return;
      quot = 64'(seed_sum) / 64'(win);
      average_reg = (quot[63:PRICE_W] != '0) ? '1 : quot[PRICE_W-1:0];
    end else begin
      blend = 64'(weight) * 64'(price) + 64'(ALPHA_ONE - weight) * 64'(average_reg)
              + 64'(HALF_LSB);
      blend = blend >> FRAC_BITS;
      average_reg = (blend[63:PRICE_W] != '0) ? '1 : blend[PRICE_W-1:0];
    end
    next_avg.average_value = average_reg;
    next_avg.result_time = stamp;
    expected_avgs = {expected_avgs, next_avg};
  endtask

  always @(posedge clk) begin
    avg_result_t got;
    avg_result_t want;
    if (!rst_n) begin
      window_reg = WIN_RESET;
      alpha_reg = ALPHA_RESET;
      samples_seen = '0;
      seed_sum = '0;
      average_reg = '0;
      expected_avgs.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WINDOW) window_reg = cfg_data[CNT_W-1:0];
        else alpha_reg = cfg_data[ALPHA_W-1:0];
      end
      if (in_tvalid && in_tready)
        update_average(in_tdata[PRICE_W-1:0], in_tdata[IN_W-1:PRICE_W], in_tuser);
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_avgs.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result: average %h time %h",
                     $realtime, got.average_value, got.result_time);
        end else begin
          want = expected_avgs.pop_front();
          if (got.average_value !== want.average_value ||
              got.result_time !== want.result_time) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: average exp %h got %h, time exp %h got %h",
                       $realtime, want.average_value, got.average_value,
                       want.result_time, got.result_time);
          end
        end
      end
    end
    pending <= expected_avgs.size();
    fail_count <= errors;
  end

endmodule

// ----- test/ema_with_sma_seed_tb.sv -----
// Top testbench for ema_with_sma_seed: clock, reset, register writes and
// stimulus with random idling on both channels. Depends on emas_pkg and the checker.
`timescale 1ns / 1ps
module ema_with_sma_seed_tb;
  import emas_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata;   // close_price[39:0], timestamp[79:40]
  logic               in_tuser;   // series_start
  logic               out_tvalid;
  logic               out_tready;
  logic [OUT_W-1:0]   out_tdata;  // average_value[39:0], result_time[79:40]
  logic               cfg_we;
  logic               cfg_index;
  logic [CFG_W-1:0]   cfg_data;
  int                 fail_count;
  int                 pending;
  int                 send_idle_pct;
  int                 recv_idle_pct;
  logic [TIME_W-1:0]  clock_stamp;

  ema_with_sma_seed dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ema_with_sma_seed_checker avg_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= recv_idle_pct);

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic send_sample(input logic [PRICE_W-1:0] price,
                             input logic [TIME_W-1:0] stamp, input logic start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {stamp, price};
    in_tuser <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_window(input logic [CNT_W-1:0] win);
    write_reg(CFG_WINDOW, {(CFG_W-CNT_W)'($urandom), win});
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 26;
        recv_idle_pct <= 47;
      end
      1: begin
        send_idle_pct = 47;
        recv_idle_pct <= 26;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
    endcase
  endtask

  function automatic logic [TIME_W-1:0] next_stamp();
    if ($urandom_range(19) == 0) clock_stamp = TIME_W'({$urandom, $urandom});
    else clock_stamp = clock_stamp + TIME_W'($urandom_range(86400, 1));
    return clock_stamp;
  endfunction

  function automatic logic [PRICE_W-1:0] pick_price(input logic [PRICE_W-1:0] base);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return PRICE_W'({$urandom, $urandom});
      default: return base + PRICE_W'($urandom_range(1 << 20));
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_window();
    case ($urandom_range(9))
      0: return '0;
      1: return CNT_W'(1);
      2, 3: return CNT_W'($urandom_range(40, 17));
      default: return CNT_W'($urandom_range(16, 2));
    endcase
  endfunction

  function automatic logic [ALPHA_W-1:0] pick_alpha();
    case ($urandom_range(9))
      0: return '0;
      1: return ALPHA_ONE;
      2: return '1;
      3, 4: return ALPHA_W'($urandom);
      default: return ALPHA_W'($urandom_range(32'(ALPHA_ONE)));
    endcase
  endfunction

  initial begin
    logic [PRICE_W-1:0] base;
    int                 pause_at;
    logic               start;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_WINDOW;
    cfg_data = '0;
    clock_stamp = '0;
    send_idle_pct = 26;
    recv_idle_pct = 47;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: seed from ten full-scale samples, then both extremes
    for (int k = 0; k < 10; k++)
      send_sample('1, k[0] ? '1 : '0, k == 0);
    send_sample('0, '1, 1'b0);
    send_sample('1, '0, 1'b0);
    drain();

    // zero window acts as one, so the first sample seeds; alpha above one follows the input
    set_window('0);
    write_reg(CFG_ALPHA, '1);
    send_sample(PRICE_W'(12345), next_stamp(), 1'b1);
    send_sample(PRICE_W'({$urandom, $urandom}), next_stamp(), 1'b0);
    drain();

    // oversized window, then shrink mid-seed, then grow to seed again
    set_window('1);
    write_reg(CFG_ALPHA, '0);
    for (int k = 0; k < 3; k++)
      send_sample(PRICE_W'({$urandom, $urandom}), next_stamp(), k == 0);
    drain();
    set_window(CNT_W'(2));
    send_sample(PRICE_W'(777), next_stamp(), 1'b0);
    drain();
    set_window(CNT_W'(6));
    for (int k = 0; k < 3; k++)
      send_sample(PRICE_W'({$urandom, $urandom}), next_stamp(), 1'b0);
    drain();

    // half-way rounding
    set_window(CNT_W'(1));
    write_reg(CFG_ALPHA, ALPHA_W'(32768));
    send_sample(PRICE_W'(1), next_stamp(), 1'b1);
    send_sample(PRICE_W'(0), next_stamp(), 1'b0);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      set_idling(ph / 4);
      set_window(pick_window());
      write_reg(CFG_ALPHA, pick_alpha());
      base = PRICE_W'({$urandom, $urandom}) >> $urandom_range(20);
      pause_at = $urandom_range(150, 20);
      for (int k = 0; k < 165; k++) begin
        if (k == pause_at) drain();
        start = (k == 0) ? 1'($urandom_range(1)) : ($urandom_range(99) < 3);
        send_sample(pick_price(base), next_stamp(), start);
      end
      drain();
    end

    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
